// ----- sv/kcl_pkg.sv -----
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and codes for the keypad code lock: screen codes, event
// codes, timer request codes and the result word carried to the output.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // default code length and configuration defaults
  localparam int CODE_DIGITS_DEF = 6;
  localparam int PACKED_DIGITS   = 6;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 24;
  localparam logic [23:0] BASE_CODE_DEF    = 24'h123456;
  localparam logic [3:0]  MAX_FAILURES_DEF = 4'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES = 1'd1;

  // event kinds
  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_TIMER = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  // keys with a meaning of their own
  localparam logic [3:0] KEY_UNLOCK = 4'd1;
  localparam logic [3:0] KEY_CHANGE = 4'd2;
  localparam logic [3:0] KEY_WARN   = 4'd3;
  localparam logic [3:0] KEY_MAX    = 4'd9;

  // screen codes
  localparam logic [3:0] SCR_MENU    = 4'd0;
  localparam logic [3:0] SCR_UNLOCK  = 4'd1;
  localparam logic [3:0] SCR_VERIFY  = 4'd2;
  localparam logic [3:0] SCR_NEWCODE = 4'd3;
  localparam logic [3:0] SCR_ACCEPT  = 4'd4;
  localparam logic [3:0] SCR_REJECT  = 4'd5;
  localparam logic [3:0] SCR_MOVING  = 4'd6;
  localparam logic [3:0] SCR_WARN    = 4'd7;
  localparam logic [3:0] SCR_RETRY   = 4'd8;

  // timer requests
  localparam logic [2:0] TMR_NONE = 3'd0;
  localparam logic [2:0] TMR_200  = 3'd1;
  localparam logic [2:0] TMR_500  = 3'd2;
  localparam logic [2:0] TMR_1000 = 3'd3;
  localparam logic [2:0] TMR_2000 = 3'd4;

  // one result word
  typedef struct packed {
    logic [3:0] screen;
    logic [2:0] timer_request;
    logic [2:0] digits_entered;
    logic [3:0] visible_digit;
    logic       digit_visible;
    logic [3:0] failures;
  } result_t;

  // screens that take digits
  function automatic logic is_entry(input logic [3:0] scr);
    return (scr == SCR_UNLOCK) || (scr == SCR_VERIFY) || (scr == SCR_NEWCODE);
  endfunction

endpackage

// ----- sv/keypad_code_lock_fsm_unit.sv -----
// ----------------------------------------------------------------------------
// keypad_code_lock_fsm_unit
// Keypad code lock controller: one result word for each accepted event.
// ----------------------------------------------------------------------------
// A result is valid on out_valid in the cycle after its event is taken
// while the output is free; under a stalled output it waits in the skid word.
// Throughput: one event per cycle while in_stall is low; the whole update is a single pass through
// the state machine and the parallel code compare ahead of the output register.
// in_stall rises only while the skid word holds a result behind a stalled one.
// Reset (rst, synchronous): menu screen, empty entry, zero failures, stored code
// and registers back to their defaults, output side empty.
module keypad_code_lock_fsm_unit #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     command,
  input  logic [3:0]                     key,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     screen,
  output logic [2:0]                     timer_request,
  output logic [2:0]                     digits_entered,
  output logic [3:0]                     visible_digit,
  output logic                           digit_visible,
  output logic [3:0]                     failures
);

  kcl_pkg::result_t next_word;
  kcl_pkg::result_t out_word;
  logic             accept;

  assign accept = in_valid && !in_stall;

  // state machine
  kcl_ctrl #(
    .CODE_DIGITS(CODE_DIGITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .command  (command),
    .key      (key),
    .result   (next_word)
  );

  // result register and skid word
  kcl_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (next_word),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_word)
  );

  assign screen         = out_word.screen;
  assign timer_request  = out_word.timer_request;
  assign digits_entered = out_word.digits_entered;
  assign visible_digit  = out_word.visible_digit;
  assign digit_visible  = out_word.digit_visible;
  assign failures       = out_word.failures;

endmodule

// ----- sv/kcl_ctrl.sv -----
// ----------------------------------------------------------------------------
// kcl_ctrl
// Lock state machine: screen state, entry digits, stored code, failure
// count and configuration registers. Computes one result word per event.
// ----------------------------------------------------------------------------
module kcl_ctrl #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           accept,
  input  logic [1:0]                     command,
  input  logic [3:0]                     key,
  output kcl_pkg::result_t               result
);

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CODE_DIGITS);

  // digit d of a packed code, leading digits beyond the packed ones are zero
  function automatic logic [3:0] code_digit(input logic [23:0] code, input int d);
    int nib;
    logic [3:0] r;
    nib = CODE_DIGITS - 1 - d;
    r   = '0;
    if (nib < kcl_pkg::PACKED_DIGITS) r = code[4*nib +: 4];
    return r;
  endfunction

  logic [23:0]      base_code;
  logic [3:0]       max_failures;
  logic [3:0]       scr, scr_next;
  logic [CNT_W-1:0] entry_count, count_next;
  logic [3:0]       failure_count, fail_next;
  logic             key_ready, ready_next;
  logic [3:0]       last_digit, last_next;
  logic [3:0]       entered_digits [CODE_DIGITS];
  logic [3:0]       stored_code [CODE_DIGITS];

  logic [3:0]       entry_view [CODE_DIGITS];
  logic [3:0]       load_view [CODE_DIGITS];
  logic [CODE_DIGITS-1:0] match_vec;
  logic             code_match;
  logic [CNT_W-1:0] count_inc;
  logic [3:0]       fail_inc;
  logic [2:0]       req;
  logic             digit_we, store_we, load_we, vis;

  // full entry view with the digit being typed in the last place, and compare
  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      entry_view[i] = (i == CODE_DIGITS - 1) ? key : entered_digits[i];
      match_vec[i]  = (entry_view[i] == stored_code[i]);
      load_view[i]  = code_digit(base_code, i);
    end
    code_match = &match_vec;
  end

  assign count_inc = entry_count + CNT_W'(1);
  assign fail_inc  = failure_count + 4'd1;

  // next state for one event
  always_comb begin
    scr_next   = scr;
    count_next = entry_count;
    fail_next  = failure_count;
    ready_next = key_ready;
    last_next  = last_digit;
    req        = kcl_pkg::TMR_NONE;
    digit_we   = 1'b0;
    store_we   = 1'b0;
    load_we    = 1'b0;
    unique case (command)
      kcl_pkg::CMD_KEY: begin
        if (scr == kcl_pkg::SCR_MENU) begin
          if (key == kcl_pkg::KEY_UNLOCK) begin
            scr_next   = kcl_pkg::SCR_UNLOCK;
            count_next = '0;
            ready_next = 1'b1;
          end else if (key == kcl_pkg::KEY_CHANGE) begin
            scr_next   = kcl_pkg::SCR_VERIFY;
            count_next = '0;
            ready_next = 1'b1;
          end else if (key >= kcl_pkg::KEY_WARN && key <= kcl_pkg::KEY_MAX) begin
            scr_next = kcl_pkg::SCR_WARN;
            req      = kcl_pkg::TMR_500;
          end
        end else if (kcl_pkg::is_entry(scr)) begin
          if (key != 4'd0 && key <= kcl_pkg::KEY_MAX && key_ready &&
              entry_count < FULL_CNT) begin
            digit_we   = 1'b1;
            last_next  = key;
            count_next = count_inc;
            ready_next = 1'b0;
            req        = kcl_pkg::TMR_200;
            // full entry is judged in the same event
            if (count_inc == FULL_CNT) begin
              count_next = '0;
              ready_next = 1'b1;
              req        = kcl_pkg::TMR_1000;
              if (scr == kcl_pkg::SCR_UNLOCK) begin
                scr_next = code_match ? kcl_pkg::SCR_ACCEPT : kcl_pkg::SCR_REJECT;
              end else if (scr == kcl_pkg::SCR_VERIFY) begin
                if (code_match) begin
                  scr_next  = kcl_pkg::SCR_MOVING;
                  fail_next = '0;
                  req       = kcl_pkg::TMR_2000;
                end else if (fail_inc >= max_failures) begin
                  scr_next  = kcl_pkg::SCR_REJECT;
                  fail_next = '0;
                  req       = kcl_pkg::TMR_2000;
                end else begin
                  scr_next  = kcl_pkg::SCR_RETRY;
                  fail_next = fail_inc;
                end
              end else begin
                store_we = 1'b1;
                scr_next = kcl_pkg::SCR_ACCEPT;
              end
            end
          end
        end
      end
      kcl_pkg::CMD_TIMER: begin
        if (scr == kcl_pkg::SCR_ACCEPT || scr == kcl_pkg::SCR_REJECT ||
            scr == kcl_pkg::SCR_WARN) begin
          scr_next = kcl_pkg::SCR_MENU;
        end else if (scr == kcl_pkg::SCR_MOVING) begin
          scr_next   = kcl_pkg::SCR_NEWCODE;
          count_next = '0;
          ready_next = 1'b1;
        end else if (scr == kcl_pkg::SCR_RETRY) begin
          scr_next   = kcl_pkg::SCR_VERIFY;
          count_next = '0;
          ready_next = 1'b1;
        end else if (kcl_pkg::is_entry(scr)) begin
          ready_next = 1'b1;
        end
      end
      kcl_pkg::CMD_RESET: begin
        scr_next   = kcl_pkg::SCR_MENU;
        fail_next  = '0;
        count_next = '0;
        ready_next = 1'b1;
        load_we    = 1'b1;
      end
      default: ;
    endcase
  end

  // result word from the updated state
  assign vis = kcl_pkg::is_entry(scr_next) && !ready_next && (count_next != '0);

  always_comb begin
    result.screen         = scr_next;
    result.timer_request  = req;
    result.digits_entered = 3'(count_next);
    result.visible_digit  = vis ? last_next : 4'd0;
    result.digit_visible  = vis;
    result.failures       = fail_next;
  end

  // control state, stored code and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base_code     <= kcl_pkg::BASE_CODE_DEF;
      max_failures  <= kcl_pkg::MAX_FAILURES_DEF;
      scr           <= kcl_pkg::SCR_MENU;
      entry_count   <= '0;
      failure_count <= '0;
      key_ready     <= 1'b1;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_code[i] <= code_digit(kcl_pkg::BASE_CODE_DEF, i);
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          kcl_pkg::REG_BASE_CODE:    base_code    <= cfg_data;
          kcl_pkg::REG_MAX_FAILURES: max_failures <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (accept) begin
        scr           <= scr_next;
        entry_count   <= count_next;
        failure_count <= fail_next;
        key_ready     <= ready_next;
        for (int i = 0; i < CODE_DIGITS; i++) begin
          if (store_we) begin
            stored_code[i] <= entry_view[i];
          end else if (load_we) begin
            stored_code[i] <= load_view[i];
          end
        end
      end
    end
  end

  // typed digits, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      last_digit <= last_next;
      if (digit_we) entered_digits[entry_count[IDX_W-1:0]] <= key;
    end
  end

endmodule

// ----- sv/kcl_out_buf.sv -----
// ----------------------------------------------------------------------------
// kcl_out_buf
// Output register with one skid word, so the controller can take one more event
// while a result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module kcl_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  kcl_pkg::result_t in_data,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output kcl_pkg::result_t out_data
);

  logic             skid_valid;
  kcl_pkg::result_t skid_data;
  logic             push, advance;

  assign in_stall = skid_valid;
  assign push     = in_valid && !skid_valid;
  assign advance  = !out_valid || !out_stall;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (advance) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // words
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (push) begin
      skid_data <= in_data;
    end
  end

endmodule

// ----- sv/kcl_checker.sv -----
// ----------------------------------------------------------------------------
// kcl_port_checks
// Port-level checks on the keypad code lock, bound to the top level.
// ----------------------------------------------------------------------------
module kcl_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] screen,
  input logic [2:0] timer_request,
  input logic [2:0] digits_entered,
  input logic [3:0] visible_digit,
  input logic       digit_visible,
  input logic [3:0] failures
);

  // input side only backs up behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // stalled word keeps its screen, visible digit and digit count
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(screen) &&
      $stable(visible_digit) && $stable(digits_entered))
    else $error("stalled result changed");

  // a clear digit only on an entry screen with digits typed
  a_visible_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_visible |-> (screen == kcl_pkg::SCR_UNLOCK ||
      screen == kcl_pkg::SCR_VERIFY || screen == kcl_pkg::SCR_NEWCODE) &&
      digits_entered != 3'd0)
    else $error("digit shown outside an entry");

  // long timer only after a verify verdict
  a_long_timer: assert property (@(posedge clk) disable iff (rst)
    out_valid && timer_request == kcl_pkg::TMR_2000 |->
      screen == kcl_pkg::SCR_MOVING || screen == kcl_pkg::SCR_REJECT)
    else $error("2000ms request on wrong screen");

  // passing verification clears the failure count
  a_moving_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && screen == kcl_pkg::SCR_MOVING |-> failures == 4'd0)
    else $error("failures left after verification passed");

endmodule

bind keypad_code_lock_fsm_unit kcl_port_checks u_kcl_port_checks (.*);
